// File: hdl/cc20_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and state encodings for the ChaCha20 stream XOR block.
// Used by the block generator and the top level; depends on nothing.

package cc20_pkg;

    localparam int WORD_W        = 32;
    localparam int BLOCK_WORDS   = 16;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int COUNT_W       = 33;
    localparam int POS_W         = 6;
    localparam int DOUBLE_ROUNDS = 10;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] t_block;

    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0      = 3'd0,
        CFG_KEY_1      = 3'd1,
        CFG_KEY_2      = 3'd2,
        CFG_KEY_3      = 3'd3,
        CFG_NONCE_LOW  = 3'd4,
        CFG_NONCE_HIGH = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_GEN,
        ST_SEND
    } t_state;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_QR,
        CS_DIAG,
        CS_UNDIAG,
        CS_FINAL
    } t_core_state;

endpackage

// File: hdl/cc20_in_if.sv
`timescale 1ns / 1ps
// Request channel carrying one byte to transform, with its message framing.
// Depends on nothing but the language.

interface cc20_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [63:0] stream_offset;

    modport source (output valid, output data_byte, output first_byte,
                    output stream_offset, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input stream_offset, output ready);
endinterface

// File: hdl/cc20_out_if.sv
`timescale 1ns / 1ps
// Result channel carrying one transformed byte and the overflow flag.
// Depends on nothing but the language.

interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       overflow;

    modport source (output valid, output data_out, output overflow, input ready);
    modport sink   (input valid, input data_out, input overflow, output ready);
endinterface

// File: hdl/cc20_core.sv
`timescale 1ns / 1ps
// ChaCha20 block generator: one shared add-xor-rotate unit stepped by a small sequencer.
// Depends on cc20_pkg.

module cc20_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cc20_pkg::t_block  i_init,
    output logic              o_done,
    output cc20_pkg::t_block  o_keystream
);

    localparam int DR_W  = $clog2(cc20_pkg::DOUBLE_ROUNDS);
    localparam int IDX_W = $clog2(cc20_pkg::BLOCK_WORDS);

    cc20_pkg::t_core_state r_state, n_state;
    cc20_pkg::t_block      r_w, n_w, r_ks, n_ks, w_step;
    logic [1:0]            r_step, n_step, r_col, n_col;
    logic                  r_diag, n_diag;
    logic [DR_W-1:0]       r_dround, n_dround;
    logic [IDX_W-1:0]      r_fidx, n_fidx;
    logic                  r_done, n_done;
    logic                  even;
    cc20_pkg::t_word       op_a, op_b, sum, mix;

    function automatic cc20_pkg::t_word f_rotl(input cc20_pkg::t_word x,
                                               input logic [1:0] step);
        case (step)
            2'd0:    f_rotl = {x[15:0], x[31:16]};
            2'd1:    f_rotl = {x[19:0], x[31:20]};
            2'd2:    f_rotl = {x[23:0], x[31:24]};
            default: f_rotl = {x[24:0], x[31:25]};
        endcase
    endfunction

    // The quarter round always works on column 0 of the 4x4 state: even steps
    // add row 1 into row 0 and mix row 3, odd steps add row 3 into row 2 and
    // mix row 1. In the feed-forward pass the same adder adds the input word.
    always_comb begin
        even = ~r_step[0];
        op_a = (r_state == cc20_pkg::CS_FINAL || even) ? r_w[0] : r_w[8];
        if (r_state == cc20_pkg::CS_FINAL) begin
            op_b = i_init[r_fidx];
        end else begin
            op_b = even ? r_w[4] : r_w[12];
        end
        sum = op_a + op_b;
        mix = f_rotl((even ? r_w[12] : r_w[4]) ^ sum, r_step);
    end

    always_comb begin
        n_state  = r_state;
        n_w      = r_w;
        n_ks     = r_ks;
        n_step   = r_step;
        n_col    = r_col;
        n_diag   = r_diag;
        n_dround = r_dround;
        n_fidx   = r_fidx;
        n_done   = 1'b0;
        w_step   = r_w;
        case (r_state)
            cc20_pkg::CS_IDLE: begin
                if (i_start) begin
                    n_w      = i_init;
                    n_step   = '0;
                    n_col    = '0;
                    n_diag   = 1'b0;
                    n_dround = '0;
                    n_state  = cc20_pkg::CS_QR;
                end
            end
            cc20_pkg::CS_QR: begin
                if (even) begin
                    w_step[0]  = sum;
                    w_step[12] = mix;
                end else begin
                    w_step[8]  = sum;
                    w_step[4]  = mix;
                end
                n_w    = w_step;
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    // Bring the next column round to position 0.
                    for (int r = 0; r < 4; r++) begin
                        for (int c = 0; c < 4; c++) begin
                            n_w[4*r + c] = w_step[4*r + ((c + 1) & 3)];
                        end
                    end
                    n_col = r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        n_state = r_diag ? cc20_pkg::CS_UNDIAG : cc20_pkg::CS_DIAG;
                    end
                end
            end
            cc20_pkg::CS_DIAG: begin
                // Shift row r left by r so the diagonals line up as columns.
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        n_w[4*r + c] = r_w[4*r + ((c + r) & 3)];
                    end
                end
                n_diag  = 1'b1;
                n_state = cc20_pkg::CS_QR;
            end
            cc20_pkg::CS_UNDIAG: begin
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        n_w[4*r + ((c + r) & 3)] = r_w[4*r + c];
                    end
                end
                n_diag = 1'b0;
                if (r_dround == DR_W'(cc20_pkg::DOUBLE_ROUNDS - 1)) begin
                    n_fidx  = '0;
                    n_state = cc20_pkg::CS_FINAL;
                end else begin
                    n_dround = r_dround + DR_W'(1);
                    n_state  = cc20_pkg::CS_QR;
                end
            end
            cc20_pkg::CS_FINAL: begin
                // The state turns as a ring; each sum enters the keystream at the top.
                for (int i = 0; i < cc20_pkg::BLOCK_WORDS - 1; i++) begin
                    n_w[i]  = r_w[i + 1];
                    n_ks[i] = r_ks[i + 1];
                end
                n_w[cc20_pkg::BLOCK_WORDS - 1]  = r_w[0];
                n_ks[cc20_pkg::BLOCK_WORDS - 1] = sum;
                n_fidx = r_fidx + IDX_W'(1);
                if (&r_fidx) begin
                    n_done  = 1'b1;
                    n_state = cc20_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = cc20_pkg::CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cc20_pkg::CS_IDLE;
            r_step   <= '0;
            r_col    <= '0;
            r_diag   <= 1'b0;
            r_dround <= '0;
            r_fidx   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_col    <= n_col;
            r_diag   <= n_diag;
            r_dround <= n_dround;
            r_fidx   <= n_fidx;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w  <= n_w;
        r_ks <= n_ks;
    end

    assign o_done      = r_done;
    assign o_keystream = r_ks;

endmodule

// File: hdl/chacha20_stream_xor.sv
`timescale 1ns / 1ps
// Top level of the ChaCha20 stream XOR block: byte sequencer, key and nonce
// registers and the output register. Depends on cc20_pkg, cc20_in_if,
// cc20_out_if and cc20_core.
//
// Usage. Key and nonce are written through the plain write port while the
// block is idle; any write to a known register drops the held keystream block.
// Each request on i_req carries one byte; a request with first_byte set starts
// a message at keystream offset stream_offset (counter offset/64+1, position
// offset%64). Each request gives exactly one result on o_rsp: the byte XORed
// with its keystream byte, or the byte unchanged with overflow set once the
// block counter has passed 2^32-1 in the message.
// Flow. A byte whose keystream block is already held goes from acceptance
// through the evaluate and send states to the output register; the next byte
// is taken only after that. A new 64-byte block is made when a message starts
// and at every 64-byte boundary by the block generator, which performs one
// 32-bit add-xor-rotate step per cycle (320 such steps, 20 row shifts and 16
// feed-forward adds per block). i_req is not ready while a byte is in work.
// Reset clears the sequencer, the key and nonce, and the stream position to
// counter 1, position 0. When the receiver stalls, the result stays in the
// output register and the next request is still taken; that request then
// waits before its own result until the register frees.

module chacha20_stream_xor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cc20_in_if.sink                         i_req,
    cc20_out_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cc20_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int CW = cc20_pkg::COUNT_W;
    localparam int WW = cc20_pkg::WORD_W;
    localparam int PW = cc20_pkg::POS_W;

    // Configuration registers.
    logic [3:0][cc20_pkg::CFG_W-1:0] r_key;
    logic [cc20_pkg::CFG_W-1:0]      r_nonce_low;
    cc20_pkg::t_word                 r_nonce_high;
    logic                            cfg_hit;

    // Stream state and the request in work.
    cc20_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    r_pos, n_pos;
    logic             r_block_ready, n_block_ready;
    logic             r_ovf, n_ovf;
    logic [7:0]       r_data, n_data;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_data, n_out_data;
    logic             r_out_ovf, n_out_ovf;

    logic             req_fire;
    logic [WW-1:0]    off_blk;
    logic             off_sat;
    logic [CW-1:0]    start_count;
    logic             count_sat;
    cc20_pkg::t_block init_words, keystream;
    cc20_pkg::t_word  ks_word;
    logic [7:0]       ks_byte;
    logic             core_start, core_done;

    assign i_req.ready = (r_state == cc20_pkg::ST_IDLE);
    assign req_fire    = i_req.valid & i_req.ready;

    // A counter above 2^32-1 is held saturated at 2^32; the top bit marks it.
    assign count_sat = r_count[CW-1];

    // Offset/64+1 exceeds 2^32-1 when any bit above the 32-bit block index is
    // set or the block index is all ones, so no wide add is needed for it.
    assign off_blk     = i_req.stream_offset[WW+PW-1:PW];
    assign off_sat     = (|i_req.stream_offset[63:WW+PW]) | (&off_blk);
    assign start_count = off_sat ? {1'b1, {WW{1'b0}}} : ({1'b0, off_blk} + CW'(1));

    // Block input: constants, key, counter and nonce.
    always_comb begin
        init_words[0]  = cc20_pkg::SIGMA_0;
        init_words[1]  = cc20_pkg::SIGMA_1;
        init_words[2]  = cc20_pkg::SIGMA_2;
        init_words[3]  = cc20_pkg::SIGMA_3;
        for (int k = 0; k < 4; k++) begin
            init_words[4 + 2*k] = r_key[k][WW-1:0];
            init_words[5 + 2*k] = r_key[k][2*WW-1:WW];
        end
        init_words[12] = r_count[WW-1:0];
        init_words[13] = r_nonce_low[WW-1:0];
        init_words[14] = r_nonce_low[2*WW-1:WW];
        init_words[15] = r_nonce_high;
    end

    cc20_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (core_start),
        .i_init      (init_words),
        .o_done      (core_done),
        .o_keystream (keystream)
    );

    assign ks_word = keystream[r_pos[PW-1:2]];
    assign ks_byte = ks_word[{r_pos[1:0], 3'b000} +: 8];

    always_comb begin
        case (i_cfg_idx)
            cc20_pkg::CFG_KEY_0,
            cc20_pkg::CFG_KEY_1,
            cc20_pkg::CFG_KEY_2,
            cc20_pkg::CFG_KEY_3,
            cc20_pkg::CFG_NONCE_LOW,
            cc20_pkg::CFG_NONCE_HIGH: cfg_hit = i_cfg_we;
            default:                  cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_nonce_low  <= '0;
            r_nonce_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cc20_pkg::CFG_KEY_0:      r_key[0]     <= i_cfg_data;
                cc20_pkg::CFG_KEY_1:      r_key[1]     <= i_cfg_data;
                cc20_pkg::CFG_KEY_2:      r_key[2]     <= i_cfg_data;
                cc20_pkg::CFG_KEY_3:      r_key[3]     <= i_cfg_data;
                cc20_pkg::CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                cc20_pkg::CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data[WW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer: take a request, fix up the stream state for a message start,
    // make a keystream block if one is needed, then hand the result over.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pos         = r_pos;
        n_block_ready = r_block_ready;
        n_ovf         = r_ovf;
        n_data        = r_data;
        n_out_valid   = r_out_valid & ~o_rsp.ready;
        n_out_data    = r_out_data;
        n_out_ovf     = r_out_ovf;
        core_start    = 1'b0;
        case (r_state)
            cc20_pkg::ST_IDLE: begin
                if (req_fire) begin
                    n_data = i_req.data_byte;
                    if (i_req.first_byte) begin
                        n_count       = start_count;
                        n_pos         = i_req.stream_offset[PW-1:0];
                        n_block_ready = 1'b0;
                        n_ovf         = 1'b0;
                    end
                    n_state = cc20_pkg::ST_EVAL;
                end
            end
            cc20_pkg::ST_EVAL: begin
                if (!count_sat && !r_block_ready) begin
                    core_start = 1'b1;
                    n_state    = cc20_pkg::ST_GEN;
                end else begin
                    n_state = cc20_pkg::ST_SEND;
                end
            end
            cc20_pkg::ST_GEN: begin
                if (core_done) begin
                    n_block_ready = 1'b1;
                    n_state       = cc20_pkg::ST_SEND;
                end
            end
            cc20_pkg::ST_SEND: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = count_sat ? r_data : (r_data ^ ks_byte);
                    n_out_ovf   = r_ovf | count_sat;
                    n_ovf       = r_ovf | count_sat;
                    n_pos       = r_pos + PW'(1);
                    // Leaving the last byte of a block moves to the next counter unless it is saturated.
                    if (&r_pos) begin
                        if (!count_sat) begin
                            n_count = r_count + CW'(1);
                        end
                        n_block_ready = 1'b0;
                    end
                    n_state = cc20_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cc20_pkg::ST_IDLE;
            end
        endcase
        if (cfg_hit) begin
            n_block_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cc20_pkg::ST_IDLE;
            r_count       <= CW'(1);
            r_pos         <= '0;
            r_block_ready <= 1'b0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_pos         <= n_pos;
            r_block_ready <= n_block_ready;
            r_ovf         <= n_ovf;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_out_data <= n_out_data;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.data_out = r_out_data;
    assign o_rsp.overflow = r_out_ovf;

`ifndef SYNTHESIS
    // A finished block only arrives while the sequencer waits for it.
    a_done_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> (r_state == cc20_pkg::ST_GEN))
        else $error("keystream block finished outside generation");

    // A byte that is XORed always has a valid keystream block behind it.
    a_block_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cc20_pkg::ST_SEND && !count_sat) |-> r_block_ready)
        else $error("keystream byte used without a generated block");

    // The overflow flag is only held while the counter is saturated.
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> count_sat)
        else $error("overflow held with counter in range");
`endif

endmodule
